// ===== sv/hncr_pkg.sv =====
// Shared types and constants for the held-note chord recognizer.
// Holds the chord pattern codes, the pitch-class table and the stage control struct.
// No dependencies.
package hncr_pkg;

  localparam int NOTE_W     = 7;
  localparam int NOTE_COUNT = 1 << NOTE_W;
  localparam int MAX_RANGE  = 64;
  localparam int SHIFT_W    = 6;
  localparam int PITCH_W    = 4;
  localparam int OCTAVE     = 12;
  localparam int HELD_OUT_W = 24;

  // chord patterns, normalized so the lowest held note is bit 0
  localparam int PAT_W = 10;
  localparam logic [PAT_W-1:0] PAT_SINGLE     = 10'd1;
  localparam logic [PAT_W-1:0] PAT_MAJ_THIRD  = 10'd17;
  localparam logic [PAT_W-1:0] PAT_MIN_THIRD  = 10'd9;
  localparam logic [PAT_W-1:0] PAT_SEMITONE   = 10'd3;
  localparam logic [PAT_W-1:0] PAT_MAJ_ROOT   = 10'd145;
  localparam logic [PAT_W-1:0] PAT_MAJ_INV1   = 10'd265;
  localparam logic [PAT_W-1:0] PAT_MAJ_INV2   = 10'd545;
  localparam logic [PAT_W-1:0] PAT_MIN_ROOT   = 10'd137;
  localparam logic [PAT_W-1:0] PAT_MIN_INV1   = 10'd529;
  localparam logic [PAT_W-1:0] PAT_MIN_INV2   = 10'd289;

  // root offsets from the lowest note
  localparam logic [PITCH_W-1:0] OFS_NONE      = 4'd0;
  localparam logic [PITCH_W-1:0] OFS_SEMITONE  = 4'd1;
  localparam logic [PITCH_W-1:0] OFS_SECOND    = 4'd5;
  localparam logic [PITCH_W-1:0] OFS_MAJ_FIRST = 4'd8;
  localparam logic [PITCH_W-1:0] OFS_MIN_FIRST = 4'd9;

  localparam logic FUNC_NOTE_ON  = 1'b0;
  localparam logic FUNC_NOTE_OFF = 1'b1;

  typedef logic [PITCH_W-1:0] mod12_lut_t [1 << SHIFT_W];

  function automatic mod12_lut_t build_mod12_lut();
    mod12_lut_t lut;
    for (int i = 0; i < (1 << SHIFT_W); i++) begin
      lut[i] = PITCH_W'(i % OCTAVE);
    end
    return lut;
  endfunction

  localparam mod12_lut_t MOD12_LUT = build_mod12_lut();

  // advance: the whole pipe moves this cycle; item: the stage holds a beat
  typedef struct packed {
    logic advance;
    logic item;
  } stage_ctl_t;

endpackage

// ===== sv/hncr_mask.sv =====
// Active and held note mask state for the chord recognizer.
// Depends on hncr_pkg.
module hncr_mask
  import hncr_pkg::*;
#(
  parameter int TRACK_RANGE = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  stage_ctl_t                     ctl_i,
  input  logic                           func_i,
  input  logic [$clog2(TRACK_RANGE)-1:0] pos_i,
  output logic [TRACK_RANGE-1:0]         held_o
);

  logic [TRACK_RANGE-1:0] active_q, active_d;
  logic [TRACK_RANGE-1:0] held_q, held_d;
  logic [TRACK_RANGE-1:0] bit_sel;

  always_comb begin
    bit_sel  = TRACK_RANGE'(1) << pos_i;
    active_d = active_q;
    held_d   = held_q;
    if (ctl_i.advance && ctl_i.item) begin
      if (func_i == FUNC_NOTE_ON) begin
        active_d = active_q | bit_sel;
        held_d   = active_d;
      end else begin
        active_d = active_q & ~bit_sel;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      held_q   <= '0;
    end else begin
      active_q <= active_d;
      held_q   <= held_d;
    end
  end

  assign held_o = held_q;

endmodule

// ===== sv/hncr_eval.sv =====
// Chord evaluation: lowest-note search, normalize, pattern match, chord state.
// Depends on hncr_pkg.
module hncr_eval
  import hncr_pkg::*;
#(
  parameter int TRACK_RANGE = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stage_ctl_t             ctl_i,
  input  logic [TRACK_RANGE-1:0] held_i,
  output logic [PITCH_W-1:0]     root_o,
  output logic                   is_minor_o,
  output logic [HELD_OUT_W-1:0]  held_notes_o
);

  localparam int SW = $clog2(TRACK_RANGE);

  logic [SW-1:0]          shift;
  logic [TRACK_RANGE-1:0] norm;
  logic                   upper_zero;
  logic                   hit;
  logic [PITCH_W-1:0]     offset;
  logic                   minor;
  logic [PITCH_W-1:0]     base;
  logic [PITCH_W:0]       sum;
  logic [MAX_RANGE-1:0]   held_ext;

  logic [PITCH_W-1:0]    root_q, root_d;
  logic                  minor_q, minor_d;
  logic [HELD_OUT_W-1:0] held_out_q;

  // lowest set bit
  always_comb begin
    shift = '0;
    for (int i = TRACK_RANGE - 1; i >= 0; i--) begin
      if (held_i[i]) shift = SW'(i);
    end
  end

  assign norm       = held_i >> shift;
  assign upper_zero = (norm >> PAT_W) == '0;
  assign base       = MOD12_LUT[SHIFT_W'(shift)];

  always_comb begin
    hit    = 1'b1;
    offset = OFS_NONE;
    minor  = 1'b0;
    case (norm[PAT_W-1:0])
      PAT_SINGLE:    ;
      PAT_MAJ_THIRD: ;
      PAT_MIN_THIRD: minor = 1'b1;
      PAT_SEMITONE:  begin
        offset = OFS_SEMITONE;
        minor  = 1'b1;
      end
      PAT_MAJ_ROOT:  ;
      PAT_MAJ_INV1:  offset = OFS_MAJ_FIRST;
      PAT_MAJ_INV2:  offset = OFS_SECOND;
      PAT_MIN_ROOT:  minor = 1'b1;
      PAT_MIN_INV1:  begin
        offset = OFS_MIN_FIRST;
        minor  = 1'b1;
      end
      PAT_MIN_INV2:  begin
        offset = OFS_SECOND;
        minor  = 1'b1;
      end
      default:       hit = 1'b0;
    endcase
    // an empty mask normalizes to zero, which never matches
    hit = hit && upper_zero;
  end

  always_comb begin
    sum     = {1'b0, base} + {1'b0, offset};
    root_d  = root_q;
    minor_d = minor_q;
    if (ctl_i.advance && ctl_i.item && hit) begin
      root_d  = (sum >= (PITCH_W + 1)'(OCTAVE)) ? PITCH_W'(sum - (PITCH_W + 1)'(OCTAVE))
                                                : PITCH_W'(sum);
      minor_d = minor;
    end
  end

  assign held_ext = MAX_RANGE'(held_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q  <= '0;
      minor_q <= 1'b0;
    end else begin
      root_q  <= root_d;
      minor_q <= minor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance && ctl_i.item) begin
      held_out_q <= held_ext[HELD_OUT_W-1:0];
    end
  end

  assign root_o       = root_q;
  assign is_minor_o   = minor_q;
  assign held_notes_o = held_out_q;

endmodule

// ===== sv/held_note_chord_recognizer.sv =====
// Held-note chord recognizer, top level.
// Throughput one beat per cycle while the output is not stalled.
// Stages: input register (note position), mask update, chord evaluation into result register.
// The pipe advances when the result register is empty or being taken; stall holds all stages.
// Reset (async, active low) clears both note masks, the chord (root 0, major) and all valids.
// Depends on hncr_pkg, hncr_mask, hncr_eval.
module held_note_chord_recognizer
  import hncr_pkg::*;
#(
  parameter int TRACK_RANGE = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [NOTE_W-1:0]     note_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PITCH_W-1:0]    root_o,
  output logic                  is_minor_o,
  output logic [HELD_OUT_W-1:0] held_notes_o
);

  localparam int PW = $clog2(TRACK_RANGE);

  typedef logic [PW-1:0] pos_lut_t [NOTE_COUNT];

  function automatic pos_lut_t build_pos_lut();
    pos_lut_t lut;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      lut[i] = PW'(i % TRACK_RANGE);
    end
    return lut;
  endfunction

  localparam pos_lut_t POS_LUT = build_pos_lut();

  logic          advance;
  logic          s1_v_q, s2_v_q, out_v_q;
  logic          s1_func_q;
  logic [PW-1:0] s1_pos_q;
  stage_ctl_t    mask_ctl, eval_ctl;
  logic [TRACK_RANGE-1:0] held;

  assign advance = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (advance) begin
      s1_v_q  <= in_valid_i;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      s1_func_q <= func_i;
      s1_pos_q  <= POS_LUT[note_i];
    end
  end

  assign mask_ctl = '{advance: advance, item: s1_v_q};
  assign eval_ctl = '{advance: advance, item: s2_v_q};

  hncr_mask #(
    .TRACK_RANGE(TRACK_RANGE)
  ) u_mask (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mask_ctl),
    .func_i (s1_func_q),
    .pos_i  (s1_pos_q),
    .held_o (held)
  );

  hncr_eval #(
    .TRACK_RANGE(TRACK_RANGE)
  ) u_eval (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (eval_ctl),
    .held_i       (held),
    .root_o       (root_o),
    .is_minor_o   (is_minor_o),
    .held_notes_o (held_notes_o)
  );

  assign in_ready_o  = advance;
  assign out_valid_o = out_v_q;

endmodule
